// ----- src/stlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlp_pkg
// Types and constants shared by the scrolled tile layer pixel unit and its
// checker.
// ----------------------------------------------------------------------------
package stlp_pkg;

   localparam int TILE_COUNT_DEFAULT = 1024;
   localparam int LINE_COUNT_DEFAULT = 256;

   // tile map geometry: 32 x 32 entries
   localparam int MAP_DEPTH = 1024;
   localparam int MAP_AW    = 10;

   // request kinds
   localparam logic [1:0] KIND_PIXEL     = 2'd0;
   localparam logic [1:0] KIND_MAP_WRITE = 2'd1;
   localparam logic [1:0] KIND_PEN_WRITE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SCROLL_X    = 2'd0;
   localparam logic [1:0] CSR_SCROLL_Y    = 2'd1;
   localparam logic [1:0] CSR_FLIP_SCREEN = 2'd2;
   localparam logic [1:0] CSR_X_ADJUST    = 2'd3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // vertical mapping of the visible strip
   localparam logic [7:0] COL_LAST     = 8'd223;
   localparam logic [7:0] NY_BASE      = 8'd239;
   localparam logic [7:0] NY_FLIP_BASE = 8'd16;

   // pens that let the lower layer show through in group 1
   localparam logic [2:0] PEN_CLEAR_A = 3'd0;
   localparam logic [2:0] PEN_CLEAR_B = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic       layer_pass;
      logic [7:0] screen_row;
      logic [7:0] screen_col;
      logic [9:0] map_index;
      logic [7:0] map_code;
      logic [7:0] map_attr;
      logic [9:0] tile_code;
      logic [3:0] tile_row;
      logic [3:0] tile_col;
      logic [2:0] pen_value;
   } req_type;

   typedef struct packed {
      logic       draw;
      logic [5:0] color_index;
      logic [2:0] pen;
   } rsp_type;

endpackage

// ----- src/scrolled_tile_layer_pixel_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolled_tile_layer_pixel_unit
// Scrolled 16x16 tile background layer: map and pen stores, pixel lookup and
// two-group priority decision.
// ----------------------------------------------------------------------------
// One request is taken every clock while the result side keeps up; each
// request gives exactly one result. The pipeline is the coordinate stage with
// the map read, the tile pen read, and the result register. Map writes land in
// the first stage and pen writes in the second, in request order, so a query
// always sees every earlier write. The stores are not cleared: querying a map
// entry or tile pixel that was never written returns arbitrary colour and pen.
// Register writes are taken at any time and must only be issued while no
// request is in flight.
module scrolled_tile_layer_pixel_unit #(
   parameter int TILE_COUNT = stlp_pkg::TILE_COUNT_DEFAULT,
   parameter int LINE_COUNT = stlp_pkg::LINE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  stlp_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output stlp_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stlp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stlp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import stlp_pkg::*;

   localparam int TILE_W    = $clog2(TILE_COUNT);
   localparam int PEN_AW    = TILE_W + 8;
   localparam int PEN_DEPTH = TILE_COUNT * 256;
   localparam int MOD_W     = TILE_W + 2;
   localparam int NX_W      = $clog2(LINE_COUNT + 64) + 2;

   // configuration
   logic [8:0]        scroll_x_ff;
   logic [8:0]        scroll_y_ff;
   logic              flip_ff;
   logic signed [6:0] x_adjust_ff;

   logic adv;

   // stage 0 logic
   logic signed [NX_W-1:0] nx_base;
   logic signed [NX_W-1:0] nx;
   logic [7:0]             ny;
   logic [8:0]             wx;
   logic [8:0]             wy;
   logic                   query_ok;
   logic                   pen_wr_ok;

   // stage 1 registers
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_query_ff;
   logic              s1_pass_ff;
   logic [3:0]        s1_px_ff;
   logic [3:0]        s1_py_ff;
   logic              s1_wr_ff;
   logic [TILE_W-1:0] s1_wr_tile_ff;
   logic [3:0]        s1_wr_row_ff;
   logic [3:0]        s1_wr_col_ff;
   logic [2:0]        s1_wr_pen_ff;
   logic [15:0]       map_rd_ff;

   // stage 1 logic
   logic [7:0]        s1_code;
   logic [7:0]        s1_attr;
   logic [MOD_W-1:0]  tile_mod;
   logic [TILE_W-1:0] tile;
   logic [3:0]        tx;
   logic [3:0]        ty;

   // stage 2 registers
   logic       s2_valid_ff, s2_valid_in;
   logic       s2_query_ff;
   logic       s2_pass_ff;
   logic [2:0] s2_color_ff;
   logic       s2_grp1_ff;
   logic [2:0] pen_rd_ff;

   // result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    opaque;

   // memories
   logic [15:0] map_mem [MAP_DEPTH];
   logic [2:0]  pen_mem [PEN_DEPTH];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff <= '0;
         scroll_y_ff <= '0;
         flip_ff     <= 1'b0;
         x_adjust_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCROLL_X:    scroll_x_ff <= csr_data;
            CSR_SCROLL_Y:    scroll_y_ff <= csr_data;
            CSR_FLIP_SCREEN: flip_ff     <= csr_data[0];
            CSR_X_ADJUST:    x_adjust_ff <= $signed(csr_data[6:0]);
            default: ;
         endcase
      end
   end

   // ---- stage 0: screen to world coordinates, map access
   always_comb begin
      nx_base = flip_ff ? (NX_W'(LINE_COUNT - 1) - NX_W'(req_payload.screen_row))
                        : NX_W'(req_payload.screen_row);
      nx      = nx_base + NX_W'(x_adjust_ff);
      ny      = flip_ff ? (NY_FLIP_BASE + req_payload.screen_col)
                        : (NY_BASE - req_payload.screen_col);
      wx      = nx[8:0] + scroll_x_ff;
      wy      = {1'b0, ny} + scroll_y_ff;
      query_ok = (req_payload.kind == KIND_PIXEL)
               && (NX_W'(req_payload.screen_row) < NX_W'(LINE_COUNT))
               && (req_payload.screen_col <= COL_LAST)
               && !nx[NX_W-1]
               && ($unsigned(nx) < NX_W'(LINE_COUNT));
      pen_wr_ok = (req_payload.kind == KIND_PEN_WRITE)
               && (MOD_W'(req_payload.tile_code) < MOD_W'(TILE_COUNT));
   end

   always_ff @(posedge clock) begin
      if (req_valid && adv && req_payload.kind == KIND_MAP_WRITE) begin
         map_mem[req_payload.map_index] <= {req_payload.map_code, req_payload.map_attr};
      end
      if (adv) begin
         map_rd_ff <= map_mem[{wx[8:4], wy[8:4]}];
      end
   end

   assign s1_valid_in = adv ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_query_ff   <= req_valid && query_ok;
         s1_pass_ff    <= req_payload.layer_pass;
         s1_px_ff      <= wx[3:0];
         s1_py_ff      <= wy[3:0];
         s1_wr_ff      <= req_valid && pen_wr_ok;
         s1_wr_tile_ff <= TILE_W'(req_payload.tile_code);
         s1_wr_row_ff  <= req_payload.tile_row;
         s1_wr_col_ff  <= req_payload.tile_col;
         s1_wr_pen_ff  <= req_payload.pen_value;
      end
   end

   // ---- stage 1: tile number, in-tile flips, pen access
   always_comb begin
      s1_code  = map_rd_ff[15:8];
      s1_attr  = map_rd_ff[7:0];
      tile_mod = MOD_W'({s1_attr[7:6], s1_code});
      // bring the banked code into the store range
      for (int i = 0; i < 3; i++) begin
         if (tile_mod >= MOD_W'(TILE_COUNT)) begin
            tile_mod = tile_mod - MOD_W'(TILE_COUNT);
         end
      end
      tile = TILE_W'(tile_mod);
      tx   = s1_attr[4] ? ~s1_px_ff : s1_px_ff;
      ty   = s1_attr[5] ? ~s1_py_ff : s1_py_ff;
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff && s1_wr_ff) begin
         pen_mem[{s1_wr_tile_ff, s1_wr_row_ff, s1_wr_col_ff}] <= s1_wr_pen_ff;
      end
      if (adv) begin
         pen_rd_ff <= pen_mem[PEN_AW'({tile, ty, tx})];
      end
   end

   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_query_ff <= s1_query_ff;
         s2_pass_ff  <= s1_pass_ff;
         s2_color_ff <= s1_attr[2:0];
         s2_grp1_ff  <= s1_attr[3];
      end
   end

   // ---- stage 2: priority decision into the result register
   always_comb begin
      opaque = s2_grp1_ff && (pen_rd_ff != PEN_CLEAR_A) && (pen_rd_ff != PEN_CLEAR_B);
      rsp_in = '0;
      if (s2_query_ff) begin
         rsp_in.draw        = s2_pass_ff ? opaque : !opaque;
         rsp_in.color_index = {s2_color_ff, pen_rd_ff};
         rsp_in.pen         = pen_rd_ff;
      end
   end

   assign rsp_valid_in = adv ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- src/stlp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlp_checker
// Port-level checks for the scrolled tile layer pixel unit.
// ----------------------------------------------------------------------------
module stlp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input stlp_pkg::rsp_type rsp_payload
);
   import stlp_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result dropped or changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // low colour bits always carry the pen
   a_color_pen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.color_index[2:0] == rsp_payload.pen)
      else $error("colour index does not match pen");

   // a transfer with the result side kept open passes stage 1 and stage 2 and shows up as a valid result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind scrolled_tile_layer_pixel_unit stlp_checker u_stlp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
